[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the RTL; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/core/pecu_pkg.sv]
// ----------------------------------------------------------------------------
// Performance counter unit package
// Operation codes, register offsets and the word types shared by the core.
// ----------------------------------------------------------------------------
package pecu_pkg;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_MEM   = 3'd1,
    OP_STALL = 3'd2,
    OP_DMA   = 3'd3,
    OP_IRQ   = 3'd4,
    OP_READ  = 3'd5,
    OP_WRITE = 3'd6
  } op_t;

  localparam logic [7:0] ADDR_CYCLES  = 8'd0;
  localparam logic [7:0] ADDR_MEM     = 8'd4;
  localparam logic [7:0] ADDR_DMA     = 8'd8;
  localparam logic [7:0] ADDR_IRQ     = 8'd12;
  localparam logic [7:0] ADDR_STALLS  = 8'd16;
  localparam logic [7:0] ADDR_CONTROL = 8'd20;

  localparam int CTRL_ENABLE_BIT = 0;
  localparam int CTRL_CLEAR_BIT  = 1;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  address;
    logic [31:0] amount;
    logic [31:0] write_data;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        bus_error;
  } result_t;

endpackage

[rtl/core/pecu_regs.sv]
// ----------------------------------------------------------------------------
// Performance counter register file
// Holds the five event counters, the control word and the count enable.
// ----------------------------------------------------------------------------
module pecu_regs
  import pecu_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    exec,
  input  item_t   item,
  output logic    has_result,
  output result_t result
);

  logic [31:0] cycle_r, mem_r, dma_r, irq_r, stall_r, control_r;
  logic [31:0] cycle_nxt, mem_nxt, dma_nxt, irq_nxt, stall_nxt, control_nxt;
  logic        enable_r, enable_nxt;
  logic        hit_cyc, hit_mem, hit_dma, hit_irq, hit_stall, hit_ctl, hit_any;
  logic        is_read, is_write, ev_en, clear;
  op_t         op;

  assign op        = op_t'(item.operation);
  assign is_read   = (op == OP_READ);
  assign is_write  = (op == OP_WRITE);
  assign hit_cyc   = (item.address == ADDR_CYCLES);
  assign hit_mem   = (item.address == ADDR_MEM);
  assign hit_dma   = (item.address == ADDR_DMA);
  assign hit_irq   = (item.address == ADDR_IRQ);
  assign hit_stall = (item.address == ADDR_STALLS);
  assign hit_ctl   = (item.address == ADDR_CONTROL);
  assign hit_any   = hit_cyc | hit_mem | hit_dma | hit_irq | hit_stall | hit_ctl;
  assign ev_en     = exec & enable_r;
  assign has_result = is_read | is_write;

  // Read data is zero for writes and for unmapped offsets.
  always_comb begin
    result.bus_error = has_result & ~hit_any;
    result.read_data = '0;
    if (is_read) begin
      if (hit_cyc)        result.read_data = cycle_r;
      else if (hit_mem)   result.read_data = mem_r;
      else if (hit_dma)   result.read_data = dma_r;
      else if (hit_irq)   result.read_data = irq_r;
      else if (hit_stall) result.read_data = stall_r;
      else if (hit_ctl)   result.read_data = control_r;
    end
  end

  always_comb begin
    cycle_nxt   = cycle_r;
    mem_nxt     = mem_r;
    dma_nxt     = dma_r;
    irq_nxt     = irq_r;
    stall_nxt   = stall_r;
    control_nxt = control_r;
    enable_nxt  = enable_r;
    clear       = 1'b0;
    unique case (op)
      OP_TICK:  if (ev_en) cycle_nxt = cycle_r + 32'd1;
      OP_MEM:   if (ev_en) mem_nxt = mem_r + 32'd1;
      OP_STALL: if (ev_en) stall_nxt = stall_r + item.amount;
      OP_DMA:   if (ev_en) dma_nxt = dma_r + item.amount;
      OP_IRQ:   if (ev_en) irq_nxt = irq_r + 32'd1;
      OP_WRITE: begin
        if (exec) begin
          if (hit_cyc)   cycle_nxt = item.write_data;
          if (hit_mem)   mem_nxt   = item.write_data;
          if (hit_dma)   dma_nxt   = item.write_data;
          if (hit_irq)   irq_nxt   = item.write_data;
          if (hit_stall) stall_nxt = item.write_data;
          if (hit_ctl) begin
            control_nxt = item.write_data;
            enable_nxt  = item.write_data[CTRL_ENABLE_BIT];
            clear       = item.write_data[CTRL_CLEAR_BIT];
          end
        end
      end
      default: ;
    endcase
    if (clear) begin
      cycle_nxt = '0;
      mem_nxt   = '0;
      dma_nxt   = '0;
      irq_nxt   = '0;
      stall_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_r   <= '0;
      mem_r     <= '0;
      dma_r     <= '0;
      irq_r     <= '0;
      stall_r   <= '0;
      control_r <= '0;
      enable_r  <= 1'b0;
    end else begin
      cycle_r   <= cycle_nxt;
      mem_r     <= mem_nxt;
      dma_r     <= dma_nxt;
      irq_r     <= irq_nxt;
      stall_r   <= stall_nxt;
      control_r <= control_nxt;
      enable_r  <= enable_nxt;
    end
  end

endmodule

[rtl/core/perf_event_counter_unit_core.sv]
// A bus access word passes through stage one and then the result register.
// Throughput: one word per cycle while in_stall is low; the counter adders are 32-bit adds.
// Event words update their counter when they leave stage one and give no result.
// Reset (rst_n low, synchronous) zeroes all counters, the control word and the enable,
// and empties both the input register and the result register.
// ----------------------------------------------------------------------------
// Performance counter unit core
// Input register, counter register file and result register for the unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module perf_event_counter_unit_core
  import pecu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_address,
  input  logic [31:0] in_amount,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic        out_bus_error
);

  // Stage one holds the accepted word. The word is executed against the
  // register file in the cycle it leaves stage one, so every word sees the
  // state left by all earlier ones.
  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r;
  logic    s1_adv, in_acc;
  logic    has_result;
  result_t result;

  // Result register; payload needs no reset.
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  logic    out_free;

  // The result register can take a new word when empty or being drained.
  assign out_free = ~out_valid_r | ~out_stall;

  // Event words never wait; bus words wait only for a free result register.
  assign s1_adv   = s1_valid_r & (~has_result | out_free);
  assign in_stall = s1_valid_r & ~s1_adv;
  assign in_acc   = in_valid & ~in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc)      s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && has_result)      out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.operation  <= in_operation;
      s1_item_r.address    <= in_address;
      s1_item_r.amount     <= in_amount;
      s1_item_r.write_data <= in_write_data;
    end
    if (s1_adv && has_result) begin
      out_res_r <= result;
    end
  end

  pecu_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .exec       (s1_adv),
    .item       (s1_item_r),
    .has_result (has_result),
    .result     (result)
  );

  assign out_valid     = out_valid_r;
  assign out_read_data = out_res_r.read_data;
  assign out_bus_error = out_res_r.bus_error;

  // An error result never carries read data.
  `ASSERT_IMP(a_err_zero_data, clk, rst_n, out_valid_r && out_res_r.bus_error, out_res_r.read_data == 32'd0, "bus error with nonzero read data")
  // Stage one only holds back when it has a bus word and the result side is blocked.
  `ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, s1_valid_r && has_result && out_valid_r && out_stall, "input stalled without cause")
  // A bus word leaving stage one always shows up in the result register.
  `ASSERT_NXT(a_result_loaded, clk, rst_n, s1_adv && has_result, out_valid_r, "bus word result lost")

endmodule
